// ===== hdl/gqr_pkg.sv =====
// Shared constants, types and helper functions of the Givens QR solver.
package gqr_pkg;

    localparam int MAX_ORDER   = 8;
    localparam int ROW_W       = $clog2(MAX_ORDER);
    localparam int COL_W       = 4;
    localparam int N_W         = 4;
    localparam int THR_W       = 17;
    localparam int VAL_W       = 32;
    localparam int MEM_DEPTH   = MAX_ORDER * MAX_ORDER + MAX_ORDER;
    localparam int MEM_AW      = $clog2(MEM_DEPTH);
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;
    localparam int ROT_BITS    = 30;
    localparam int FRAC_BITS   = 16;

    // One classified request, as it travels from the front to the solver.
    typedef struct packed {
        logic                     wr;
        logic [MEM_AW-1:0]        addr;
        logic signed [VAL_W-1:0]  value;
        logic                     start;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } div_resp_t;

    // Matrix element (row, col) lives at row*MAX_ORDER+col; column n selects the
    // right-hand side, kept after the matrix.
    function automatic logic [MEM_AW-1:0] elem_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col,
                                                    input logic [N_W-1:0]   n);
        logic [MEM_AW-1:0] a;
        if (col == n) begin
            a = MEM_AW'(MAX_ORDER * MAX_ORDER) + MEM_AW'(row);
        end else begin
            a = MEM_AW'(row) * MEM_AW'(MAX_ORDER) + MEM_AW'(col[ROW_W-1:0]);
        end
        return a;
    endfunction

    function automatic logic [N_W-1:0] order_clamp(input logic [N_W-1:0] sz);
        logic [N_W-1:0] n;
        if (sz < N_W'(2)) begin
            n = N_W'(2);
        end else if (sz > N_W'(MAX_ORDER)) begin
            n = N_W'(MAX_ORDER);
        end else begin
            n = sz;
        end
        return n;
    endfunction

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

    // Round at bit 30, half toward +inf, then saturate.
    function automatic logic signed [VAL_W-1:0] rnd30_sat(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = (v + (64'sd1 <<< (ROT_BITS - 1))) >>> ROT_BITS;
        return sat32(t);
    endfunction

endpackage

// ===== hdl/gqr_queue.sv =====
// Small request queue between the load front and the solver.
module gqr_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  gqr_pkg::item_t        push_item,
    input  logic                  pop,
    output gqr_pkg::item_t        head_item,
    output gqr_pkg::fifo_stat_t   stat
);

    gqr_pkg::item_t                 slot_reg [gqr_pkg::QDEPTH];
    logic [gqr_pkg::QPTR_W-1:0]     wptr_reg;
    logic [gqr_pkg::QPTR_W-1:0]     rptr_reg;
    logic [gqr_pkg::QPTR_W:0]       count_reg;

    assign stat.full  = (count_reg == (gqr_pkg::QPTR_W+1)'(gqr_pkg::QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign head_item  = slot_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/gqr_front.sv =====
// Input front: takes element requests, decides where each one goes and queues it.
module gqr_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gqr_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    input  logic [gqr_pkg::N_W-1:0]       order_n,
    input  gqr_pkg::fifo_stat_t           q_stat,
    output logic                          q_push,
    output gqr_pkg::item_t                q_item
);

    logic [gqr_pkg::ROW_W-1:0]        row;
    logic [gqr_pkg::COL_W-1:0]        col;
    logic                             valid_reg;
    gqr_pkg::item_t                   item_reg;
    gqr_pkg::item_t                   item_next;

    assign row = s_tdata[gqr_pkg::ROW_W-1:0];
    assign col = s_tdata[gqr_pkg::ROW_W +: gqr_pkg::COL_W];

    // Out-of-range elements are dropped, but a start flag on them still counts.
    always_comb begin
        item_next.wr    = ({1'b0, row} < order_n) && (col <= order_n);
        item_next.addr  = gqr_pkg::elem_addr(row, col, order_n);
        item_next.value = s_tdata[gqr_pkg::ROW_W + gqr_pkg::COL_W +: gqr_pkg::VAL_W];
        item_next.start = s_tlast;
    end

    assign q_push   = valid_reg && !q_stat.full;
    assign s_tready = !valid_reg || q_push;
    assign q_item   = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== hdl/gqr_div.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
module gqr_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [63:0]          dividend,
    input  logic [31:0]          divisor,
    output gqr_pkg::div_resp_t   resp
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] dvd_reg;
    logic [31:0] rem_reg;
    logic [31:0] dsr_reg;
    logic [32:0] rem_sh;
    logic        ge;
    logic [32:0] rem_next;

    assign rem_sh   = {rem_reg, dvd_reg[63]};
    assign ge       = rem_sh >= {1'b0, dsr_reg};
    assign rem_next = ge ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;

    assign resp.done = done_reg;
    assign resp.quot = dvd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[62:0], ge};
            rem_reg <= rem_next[31:0];
        end
    end

endmodule

// ===== hdl/gqr_back.sv =====
// Solver: stores elements, runs the Givens rotations, diagonal check, back substitution and output.
module gqr_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [gqr_pkg::N_W-1:0]       order_n,
    input  logic [gqr_pkg::THR_W-1:0]     thr,
    input  gqr_pkg::fifo_stat_t           q_stat,
    input  gqr_pkg::item_t                q_head,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gqr_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_RD_A, ST_RD_B, ST_SQ_A, ST_SQ_B, ST_SQ_C, ST_SQRT, ST_D_CHK,
        ST_DIV_C, ST_DIV_S, ST_RD_X, ST_RD_Y, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5,
        ST_M6, ST_NEXT_PAIR, ST_CHK_RD, ST_CHK_T, ST_BS_RB, ST_BS_LB, ST_BS_RR,
        ST_BS_MUL, ST_BS_ACC, ST_BS_DR, ST_BS_DS, ST_BS_DW, ST_BS_NEXT, ST_OUT
    } state_t;

    localparam int N_W   = gqr_pkg::N_W;
    localparam int ROW_W = gqr_pkg::ROW_W;
    localparam int VAL_W = gqr_pkg::VAL_W;

    state_t                      state_reg;
    logic [N_W-1:0]              i_reg;
    logic [N_W-1:0]              j_reg;
    logic [N_W-1:0]              k_reg;
    logic signed [VAL_W-1:0]     a_reg;
    logic signed [VAL_W-1:0]     b_reg;
    logic signed [VAL_W-1:0]     x_reg;
    logic signed [VAL_W-1:0]     y_reg;
    logic signed [VAL_W-1:0]     c_reg;
    logic signed [VAL_W-1:0]     s_reg;
    logic signed [63:0]          prod_reg;
    logic signed [63:0]          acc_reg;
    logic signed [63:0]          accp_reg;
    logic [63:0]                 sq_v_reg;
    logic [63:0]                 sq_r_reg;
    logic [4:0]                  sq_cnt_reg;
    logic [31:0]                 d_reg;
    logic                        neg_reg;
    logic signed [VAL_W-1:0]     sol_reg [gqr_pkg::MAX_ORDER];
    logic                        div_start_reg;
    logic [63:0]                 div_dvd_reg;
    logic [31:0]                 div_dsr_reg;
    logic                        m_tvalid_reg;
    logic [ROW_W-1:0]            m_idx_reg;
    logic signed [VAL_W-1:0]     m_val_reg;
    logic                        m_sing_reg;
    logic                        m_last_reg;

    logic signed [VAL_W-1:0]     mem [gqr_pkg::MEM_DEPTH];
    logic signed [VAL_W-1:0]     rdata_reg;
    logic [gqr_pkg::MEM_AW-1:0]  raddr;
    logic [gqr_pkg::MEM_AW-1:0]  waddr;
    logic signed [VAL_W-1:0]     wdata;
    logic                        we;

    logic signed [VAL_W-1:0]     mul_a;
    logic signed [VAL_W-1:0]     mul_b;
    logic [ROW_W-1:0]            sol_ridx;
    logic signed [VAL_W-1:0]     sol_rd;
    gqr_pkg::div_resp_t          div_resp;

    logic [63:0]                 sq_bit;
    logic [63:0]                 sq_try;
    logic [31:0]                 mag_a;
    logic [31:0]                 mag_b;
    logic [31:0]                 mag_rd;
    logic [63:0]                 mag_acc;
    logic [63:0]                 sq_r_next;
    logic [N_W-1:0]              i_inc;

    gqr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (div_dvd_reg),
        .divisor  (div_dsr_reg),
        .resp     (div_resp)
    );

    assign mag_a   = a_reg[VAL_W-1] ? (32'd0 - 32'(a_reg)) : 32'(a_reg);
    assign mag_b   = b_reg[VAL_W-1] ? (32'd0 - 32'(b_reg)) : 32'(b_reg);
    assign mag_rd  = rdata_reg[VAL_W-1] ? (32'd0 - 32'(rdata_reg)) : 32'(rdata_reg);
    assign mag_acc = acc_reg[63] ? (64'd0 - 64'(acc_reg)) : 64'(acc_reg);
    assign sq_bit  = 64'd1 << {sq_cnt_reg, 1'b0};
    assign sq_try  = sq_r_reg + sq_bit;
    assign sq_r_next = (sq_v_reg >= sq_try) ? ((sq_r_reg >> 1) + sq_bit) : (sq_r_reg >> 1);
    assign i_inc   = i_reg + 1'b1;
    assign sol_rd  = sol_reg[sol_ridx];

    assign q_pop    = (state_reg == ST_IDLE) && !q_stat.empty;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(gqr_pkg::M_TDATA_W - VAL_W - ROW_W){1'b0}}, m_val_reg, m_idx_reg};
    assign m_tuser  = m_sing_reg;
    assign m_tlast  = m_last_reg;

    // Memory addressing, write port and multiplier operands by state.
    always_comb begin
        raddr    = gqr_pkg::elem_addr(i_reg[ROW_W-1:0], i_reg, order_n);
        we       = 1'b0;
        waddr    = q_head.addr;
        wdata    = q_head.value;
        mul_a    = '0;
        mul_b    = '0;
        sol_ridx = j_reg[ROW_W-1:0];
        case (state_reg)
            ST_IDLE: begin
                we = q_pop && q_head.wr;
            end
            ST_RD_B: raddr = gqr_pkg::elem_addr(j_reg[ROW_W-1:0], i_reg, order_n);
            ST_RD_X: raddr = gqr_pkg::elem_addr(i_reg[ROW_W-1:0], k_reg, order_n);
            ST_RD_Y: raddr = gqr_pkg::elem_addr(j_reg[ROW_W-1:0], k_reg, order_n);
            ST_BS_RB: raddr = gqr_pkg::elem_addr(i_reg[ROW_W-1:0], order_n, order_n);
            ST_BS_RR: raddr = gqr_pkg::elem_addr(i_reg[ROW_W-1:0], j_reg, order_n);
            ST_SQ_A: begin
                mul_a = a_reg;
                mul_b = a_reg;
            end
            ST_SQ_B: begin
                mul_a = b_reg;
                mul_b = b_reg;
            end
            ST_M1: begin
                mul_a = c_reg;
                mul_b = x_reg;
            end
            ST_M2: begin
                mul_a = s_reg;
                mul_b = y_reg;
            end
            ST_M3: begin
                mul_a = c_reg;
                mul_b = y_reg;
            end
            ST_M4: begin
                mul_a = s_reg;
                mul_b = x_reg;
                we    = 1'b1;
                waddr = gqr_pkg::elem_addr(i_reg[ROW_W-1:0], k_reg, order_n);
                wdata = gqr_pkg::rnd30_sat(accp_reg);
            end
            ST_M6: begin
                we    = 1'b1;
                waddr = gqr_pkg::elem_addr(j_reg[ROW_W-1:0], k_reg, order_n);
                wdata = gqr_pkg::rnd30_sat(accp_reg);
            end
            ST_BS_MUL: begin
                mul_a = rdata_reg;
                mul_b = sol_rd;
            end
            ST_BS_NEXT: sol_ridx = '0;
            ST_OUT: sol_ridx = i_inc[ROW_W-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            div_start_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            sq_cnt_reg    <= '0;
        end else begin
            div_start_reg <= 1'b0;
            prod_reg      <= 64'(mul_a) * 64'(mul_b);
            case (state_reg)
                ST_IDLE: begin
                    if (q_pop && q_head.start) begin
                        i_reg     <= '0;
                        j_reg     <= N_W'(1);
                        state_reg <= ST_RD_A;
                    end
                end
                ST_RD_A: state_reg <= ST_RD_B;
                ST_RD_B: begin
                    a_reg     <= rdata_reg;
                    state_reg <= ST_SQ_A;
                end
                ST_SQ_A: begin
                    b_reg     <= rdata_reg;
                    state_reg <= ST_SQ_B;
                end
                ST_SQ_B: begin
                    acc_reg   <= prod_reg;
                    state_reg <= ST_SQ_C;
                end
                ST_SQ_C: begin
                    sq_v_reg   <= 64'(acc_reg) + 64'(prod_reg);
                    sq_r_reg   <= '0;
                    sq_cnt_reg <= 5'd31;
                    state_reg  <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (sq_v_reg >= sq_try) begin
                        sq_v_reg <= sq_v_reg - sq_try;
                    end
                    sq_r_reg <= sq_r_next;
                    if (sq_cnt_reg == '0) begin
                        d_reg     <= sq_r_next[31:0];
                        state_reg <= ST_D_CHK;
                    end else begin
                        sq_cnt_reg <= sq_cnt_reg - 1'b1;
                    end
                end
                ST_D_CHK: begin
                    if (d_reg <= 32'(thr)) begin
                        state_reg <= ST_NEXT_PAIR;
                    end else begin
                        div_dvd_reg   <= (64'(mag_a) << gqr_pkg::ROT_BITS) + 64'(d_reg >> 1);
                        div_dsr_reg   <= d_reg;
                        div_start_reg <= 1'b1;
                        neg_reg       <= a_reg[VAL_W-1];
                        state_reg     <= ST_DIV_C;
                    end
                end
                ST_DIV_C: begin
                    if (div_resp.done) begin
                        c_reg         <= neg_reg ? (32'sd0 - $signed(div_resp.quot[31:0]))
                                                 : $signed(div_resp.quot[31:0]);
                        div_dvd_reg   <= (64'(mag_b) << gqr_pkg::ROT_BITS) + 64'(d_reg >> 1);
                        div_start_reg <= 1'b1;
                        neg_reg       <= b_reg[VAL_W-1];
                        state_reg     <= ST_DIV_S;
                    end
                end
                ST_DIV_S: begin
                    if (div_resp.done) begin
                        s_reg     <= neg_reg ? (32'sd0 - $signed(div_resp.quot[31:0]))
                                             : $signed(div_resp.quot[31:0]);
                        k_reg     <= i_reg;
                        state_reg <= ST_RD_X;
                    end
                end
                ST_RD_X: state_reg <= ST_RD_Y;
                ST_RD_Y: begin
                    x_reg     <= rdata_reg;
                    state_reg <= ST_M1;
                end
                ST_M1: begin
                    y_reg     <= rdata_reg;
                    state_reg <= ST_M2;
                end
                ST_M2: begin
                    acc_reg   <= prod_reg;
                    state_reg <= ST_M3;
                end
                ST_M3: begin
                    accp_reg  <= acc_reg + prod_reg;
                    state_reg <= ST_M4;
                end
                ST_M4: begin
                    acc_reg   <= prod_reg;
                    state_reg <= ST_M5;
                end
                ST_M5: begin
                    accp_reg  <= acc_reg - prod_reg;
                    state_reg <= ST_M6;
                end
                ST_M6: begin
                    // The right-hand side rides along as column n.
                    if (k_reg == order_n) begin
                        state_reg <= ST_NEXT_PAIR;
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_RD_X;
                    end
                end
                ST_NEXT_PAIR: begin
                    if ((j_reg + 1'b1) < order_n) begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_RD_A;
                    end else if ((i_reg + N_W'(2)) < order_n) begin
                        i_reg     <= i_inc;
                        j_reg     <= i_reg + N_W'(2);
                        state_reg <= ST_RD_A;
                    end else begin
                        i_reg     <= '0;
                        state_reg <= ST_CHK_RD;
                    end
                end
                ST_CHK_RD: state_reg <= ST_CHK_T;
                ST_CHK_T: begin
                    if (mag_rd <= 32'(thr)) begin
                        m_tvalid_reg <= 1'b1;
                        m_idx_reg    <= '0;
                        m_val_reg    <= '0;
                        m_sing_reg   <= 1'b1;
                        m_last_reg   <= 1'b1;
                        state_reg    <= ST_OUT;
                    end else if (i_inc == order_n) begin
                        i_reg     <= order_n - 1'b1;
                        state_reg <= ST_BS_RB;
                    end else begin
                        i_reg     <= i_inc;
                        state_reg <= ST_CHK_RD;
                    end
                end
                ST_BS_RB: begin
                    j_reg     <= i_inc;
                    state_reg <= ST_BS_LB;
                end
                ST_BS_LB: begin
                    acc_reg   <= 64'(rdata_reg);
                    state_reg <= (j_reg == order_n) ? ST_BS_DR : ST_BS_RR;
                end
                ST_BS_RR: state_reg <= ST_BS_MUL;
                ST_BS_MUL: state_reg <= ST_BS_ACC;
                ST_BS_ACC: begin
                    acc_reg <= acc_reg
                        - ((prod_reg + (64'sd1 <<< (gqr_pkg::FRAC_BITS - 1)))
                           >>> gqr_pkg::FRAC_BITS);
                    j_reg     <= j_reg + 1'b1;
                    state_reg <= ((j_reg + 1'b1) == order_n) ? ST_BS_DR : ST_BS_RR;
                end
                ST_BS_DR: state_reg <= ST_BS_DS;
                ST_BS_DS: begin
                    neg_reg <= acc_reg[63] != rdata_reg[VAL_W-1];
                    if (|mag_acc[63:47]) begin
                        sol_reg[i_reg[ROW_W-1:0]] <=
                            (acc_reg[63] != rdata_reg[VAL_W-1]) ? 32'sh80000000
                                                                : 32'sh7fffffff;
                        state_reg <= ST_BS_NEXT;
                    end else begin
                        div_dvd_reg   <= (mag_acc << gqr_pkg::FRAC_BITS) + 64'(mag_rd >> 1);
                        div_dsr_reg   <= mag_rd;
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_BS_DW;
                    end
                end
                ST_BS_DW: begin
                    if (div_resp.done) begin
                        if (neg_reg) begin
                            sol_reg[i_reg[ROW_W-1:0]] <=
                                (div_resp.quot > 64'h80000000) ? 32'sh80000000
                                : (32'sd0 - $signed(div_resp.quot[31:0]));
                        end else begin
                            sol_reg[i_reg[ROW_W-1:0]] <=
                                (div_resp.quot > 64'h7fffffff) ? 32'sh7fffffff
                                : $signed(div_resp.quot[31:0]);
                        end
                        state_reg <= ST_BS_NEXT;
                    end
                end
                ST_BS_NEXT: begin
                    if (i_reg == '0) begin
                        m_tvalid_reg <= 1'b1;
                        m_idx_reg    <= '0;
                        m_val_reg    <= sol_rd;
                        m_sing_reg   <= 1'b0;
                        m_last_reg   <= 1'b0;
                        state_reg    <= ST_OUT;
                    end else begin
                        i_reg     <= i_reg - 1'b1;
                        state_reg <= ST_BS_RB;
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        if (m_last_reg) begin
                            m_tvalid_reg <= 1'b0;
                            state_reg    <= ST_IDLE;
                        end else begin
                            i_reg      <= i_inc;
                            m_idx_reg  <= i_inc[ROW_W-1:0];
                            m_val_reg  <= sol_rd;
                            m_last_reg <= (i_inc + 1'b1) == order_n;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/givens_qr_linear_solver.sv =====
// Top level of the Givens-rotation QR linear solver with its register port.
//
//  channel   direction  request contents
//  s_*       in         one matrix or right-hand-side element, tlast starts the solve
//  m_*       out        one solution component, tuser flags a singular matrix
//  APB       in/out     matrix_size (0x0), small_threshold (0x4)
//
// Elements are taken one per cycle while the solver is idle; a request queue of
// four entries keeps the input open while the solver finishes earlier work.
// A solve runs, per rotation pair, the reads and square root, two divisions by the
// bit-serial divider and the rotation, unless the pair is skipped; then the diagonal
// check of each row and back substitution row by row; output is one per cycle while
// m_tready is high.
// Reset is synchronous, active low, and clears all control state.
// The output holds its request until m_tready; the solver waits meanwhile.
module givens_qr_linear_solver (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [2:0] row_index, [6:3] column_index, [38:7] element_value, [39] zero
    input  logic [gqr_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] solution_index, [34:3] solution_value, [39:35] zero
    output logic [gqr_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] singular
    output logic                          m_tuser,
    output logic                          m_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [gqr_pkg::N_W-1:0]    matrix_size_reg;
    logic [gqr_pkg::THR_W-1:0]  thr_reg;
    logic [gqr_pkg::N_W-1:0]    order_n;
    logic                       cfg_wr;
    logic                       q_push;
    logic                       q_pop;
    gqr_pkg::item_t             q_item;
    gqr_pkg::item_t             q_head;
    gqr_pkg::fifo_stat_t        q_stat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = paddr[2] ? 32'(thr_reg) : 32'(matrix_size_reg);
    assign order_n = gqr_pkg::order_clamp(matrix_size_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matrix_size_reg <= gqr_pkg::N_W'(8);
            thr_reg         <= gqr_pkg::THR_W'(1);
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                thr_reg <= pwdata[gqr_pkg::THR_W-1:0];
            end else begin
                matrix_size_reg <= pwdata[gqr_pkg::N_W-1:0];
            end
        end
    end

    gqr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .order_n  (order_n),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_item   (q_item)
    );

    gqr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .head_item (q_head),
        .stat      (q_stat)
    );

    gqr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .order_n  (order_n),
        .thr      (thr_reg),
        .q_stat   (q_stat),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_singular_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata[34:3] == 32'd0))
        else $error("singular result must be last with zero value");

    a_queue_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    a_no_pop_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !q_pop)
        else $error("solver took a request while results were pending");

    a_size_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr && !paddr[2] |=> matrix_size_reg == $past(pwdata[3:0]))
        else $error("matrix_size write lost");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench of the Givens QR linear solver: directed and random systems.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [2:0] REG_SIZE = 3'd0;
    localparam logic [2:0] REG_THR  = 3'd4;
    localparam int         LONG_HOLD = 3000;

    typedef struct {
        logic [2:0]  idx;
        logic [31:0] val;
        bit          sing;
        bit          last;
    } sol_t;

    typedef struct {
        logic [2:0]  r;
        logic [3:0]  c;
        logic [31:0] v;
        bit          go;
    } elem_t;

    // Directed row; nexp of zero means the solver model decides the results.
    typedef struct {
        logic [2:0]  r;
        logic [3:0]  c;
        logic [31:0] v;
        bit          go;
        int          nexp;
        logic [31:0] x0;
        logic [31:0] x1;
        bit          sing;
    } dir_row_t;

    logic        aclk, aresetn;
    logic        s_tvalid, s_tready, s_tlast;
    logic [39:0] s_tdata;
    logic        m_tvalid, m_tready, m_tuser, m_tlast;
    logic [39:0] m_tdata;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    givens_qr_linear_solver dut (.*);

    // Solver model state.
    longint  mat [64];
    longint  rhs [8];
    longint  xsol [8];
    bit      mat_wr [64];
    bit      rhs_wr [8];
    int      cfg_size;
    longint  cfg_thr;

    sol_t    solution_q [$];
    int      fails;
    int      src_idle_pct, snk_stall_pct;
    int      hold_reqs;

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    function automatic int order_n();
        return (cfg_size < 2) ? 2 : (cfg_size > 8) ? 8 : cfg_size;
    endfunction

    function automatic longint unsigned absval(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint round_shift(longint v, int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint cos_sin(longint x, longint unsigned d);
        longint unsigned q;
        q = ((absval(x) << 30) + d / 2) / d;
        return (x < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint quotient(longint acc, longint r);
        longint unsigned ma, mr, q;
        bit neg;
        ma = absval(acc);
        mr = absval(r);
        neg = (acc < 0) != (r < 0);
        if (ma >= (64'd1 << 47)) return neg ? -64'sd2147483648 : 64'sd2147483647;
        q = ((ma << 16) + mr / 2) / mr;
        if (neg) return (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
        return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
    endfunction

    task automatic rotate_pair(ref longint p, ref longint q, input longint c, input longint s);
        longint x, y;
        x = p;
        y = q;
        p = clip32(round_shift(c * x + s * y, 30));
        q = clip32(round_shift(c * y - s * x, 30));
    endtask

    task automatic solve_system(output sol_t res[$]);
        int n;
        longint a, b, c, s, acc;
        longint unsigned d;
        sol_t e;
        n = order_n();
        res.delete();
        for (int i = 0; i < n - 1; i++) begin
            for (int j = i + 1; j < n; j++) begin
                a = mat[i*8+i];
                b = mat[j*8+i];
                d = int_sqrt(absval(a) * absval(a) + absval(b) * absval(b));
                if (d <= cfg_thr) continue;
                c = cos_sin(a, d);
                s = cos_sin(b, d);
                for (int k = i; k < n; k++) rotate_pair(mat[i*8+k], mat[j*8+k], c, s);
                rotate_pair(rhs[i], rhs[j], c, s);
            end
        end
        for (int i = 0; i < n; i++) begin
            if (absval(mat[i*8+i]) <= cfg_thr) begin
                e = '{idx: 3'd0, val: 32'd0, sing: 1'b1, last: 1'b1};
                res.insert(res.size(), e);
                return;
            end
        end
        for (int i = n - 1; i >= 0; i--) begin
            acc = rhs[i];
            for (int j = i + 1; j < n; j++) acc -= round_shift(mat[i*8+j] * xsol[j], 16);
            xsol[i] = quotient(acc, mat[i*8+i]);
        end
        for (int i = 0; i < n; i++) begin
            e = '{idx: 3'(i), val: xsol[i][31:0], sing: 1'b0, last: (i == n - 1)};
            res.insert(res.size(), e);
        end
    endtask

    // Stores one accepted element, then solves when it carries the start flag.
    task automatic absorb_element(input elem_t el, output sol_t res[$]);
        int n;
        n = order_n();
        res.delete();
        if (el.r < n) begin
            if (el.c < n) begin
                mat[el.r*8+el.c] = longint'(signed'(el.v));
                mat_wr[el.r*8+el.c] = 1'b1;
            end else if (el.c == n) begin
                rhs[el.r] = longint'(signed'(el.v));
                rhs_wr[el.r] = 1'b1;
            end
        end
        if (el.go) solve_system(res);
    endtask

    function automatic bit store_complete();
        int n;
        n = order_n();
        for (int r = 0; r < n; r++) begin
            if (!rhs_wr[r]) return 0;
            for (int c = 0; c < n; c++) if (!mat_wr[r*8+c]) return 0;
        end
        return 1;
    endfunction

    // Drives one request; returns after acceptance at the following falling edge.
    task automatic send_element(input elem_t el, output sol_t res[$]);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, el.v, el.c, el.r};
        s_tlast  <= el.go;
        do @(posedge aclk); while (!s_tready);
        absorb_element(el, res);
        @(negedge aclk);
    endtask

    task automatic send_and_predict(input elem_t el);
        sol_t res[$];
        send_element(el, res);
        foreach (res[i]) solution_q.insert(solution_q.size(), res[i]);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == REG_SIZE) cfg_size = data[3:0];
        else cfg_thr = data[16:0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (solution_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] random_value(bit diag);
        int unsigned mag;
        if ($urandom_range(5) == 0) return $urandom;
        if (diag && $urandom_range(3) != 0) begin
            mag = $urandom_range(32'h0008_0000, 32'h0002_0000);
            return $urandom_range(1) ? mag : -mag;
        end
        return $urandom_range(32'h0008_0000) - 32'h0004_0000;
    endfunction

    // One system: a full load (or a partial reload), scattered ignored requests,
    // and a start flag on the last request.
    task automatic send_system(output int count);
        elem_t list[$];
        elem_t el;
        int n, k;
        bit partial;
        n = order_n();
        partial = store_complete() && ($urandom_range(3) == 0);
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c <= n; c++) begin
                if (partial && $urandom_range(2) != 0) continue;
                el = '{r: 3'(r), c: 4'(c), v: random_value(r == c), go: 1'b0};
                list.insert(list.size(), el);
            end
        end
        list.shuffle();
        k = $urandom_range(n / 2 + 1);
        for (int i = 0; i < k; i++) begin
            el.r = 3'($urandom_range(7));
            el.c = 4'($urandom_range(15));
            if (el.r < n && el.c <= n) el.c = 4'(n + 1 + $urandom_range(14 - n));
            el.v = $urandom;
            el.go = 1'b0;
            list.insert($urandom_range(list.size()), el);
        end
        if (list.size() == 0) begin
            el = '{r: 3'd0, c: 4'(n), v: random_value(0), go: 1'b0};
            list.insert(list.size(), el);
        end
        list[list.size()-1].go = 1'b1;
        foreach (list[i]) send_and_predict(list[i]);
        count = list.size();
    endtask

    // Result channel: random stalls, plus a long hold whenever one is requested.
    initial begin
        int seen, hold_left;
        seen = 0;
        hold_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_reqs != seen) begin
                seen = hold_reqs;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        sol_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (solution_q.size() == 0) begin
                $error("unexpected solution request: tdata=%h", m_tdata);
                fails++;
            end else begin
                e = solution_q.pop_front();
                if (m_tdata[2:0] !== e.idx) begin
                    $error("solution_index: expected %0d, got %0d", e.idx, m_tdata[2:0]);
                    fails++;
                end
                if (m_tdata[34:3] !== e.val) begin
                    $error("solution_value: expected %h, got %h", e.val, m_tdata[34:3]);
                    fails++;
                end
                if (m_tuser !== e.sing) begin
                    $error("singular: expected %0b, got %0b", e.sing, m_tuser);
                    fails++;
                end
                if (m_tlast !== e.last) begin
                    $error("last_result: expected %0b, got %0b", e.last, m_tlast);
                    fails++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("** givens_qr_linear_solver: FAILED **");
        $finish;
    end

    initial begin
        dir_row_t dir_rows[$];
        sol_t res[$];
        sol_t e;
        elem_t el;
        int sizes[12];
        int thrs[12];
        int idle_src[4];
        int idle_snk[4];
        int sent, cnt;

        sizes = '{2, 3, 0, 4, 15, 2, 5, 1, 3, 6, 7, 4};
        thrs = '{1, 0, 65536, 1, 37, 0, 1, 200, 65536, 1, 3, 0};
        idle_src = '{0, 72, 0, 36};
        idle_snk = '{0, 0, 72, 36};
        fails = 0;
        hold_reqs = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        cfg_size = 8;
        cfg_thr = 1;
        foreach (mat[i]) begin
            mat[i] = 0;
            mat_wr[i] = 0;
        end
        foreach (rhs[i]) begin
            rhs[i] = 0;
            xsol[i] = 0;
            rhs_wr[i] = 0;
        end
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Identity system, an all-zero (singular) matrix, a start-only request that
        // still starts a solve, ignored out-of-range loads, and full-scale values.
        dir_rows = '{
            '{0, 0, 32'h0001_0000, 0, 0, 0, 0, 0},
            '{0, 1, 32'h0000_0000, 0, 0, 0, 0, 0},
            '{1, 0, 32'h0000_0000, 0, 0, 0, 0, 0},
            '{1, 1, 32'h0001_0000, 0, 0, 0, 0, 0},
            '{0, 2, 32'h0003_0000, 0, 0, 0, 0, 0},
            '{1, 2, 32'hFFFE_0000, 1, 2, 32'h0003_0000, 32'hFFFE_0000, 0},
            '{0, 0, 32'h0000_0000, 0, 0, 0, 0, 0},
            '{0, 1, 32'h0000_0000, 0, 0, 0, 0, 0},
            '{1, 0, 32'h0000_0000, 0, 0, 0, 0, 0},
            '{1, 1, 32'h0000_0000, 0, 0, 0, 0, 0},
            '{0, 2, 32'h0000_0005, 0, 0, 0, 0, 0},
            '{1, 2, 32'h0000_0007, 1, 1, 0, 0, 1},
            '{7, 15, 32'h1234_5678, 1, 1, 0, 0, 1},
            '{2, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0},
            '{0, 3, 32'h8000_0000, 0, 0, 0, 0, 0},
            '{0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0},
            '{0, 1, 32'h8000_0000, 0, 0, 0, 0, 0},
            '{1, 0, 32'h8000_0000, 0, 0, 0, 0, 0},
            '{1, 1, 32'h7FFF_FFFF, 0, 0, 0, 0, 0},
            '{0, 2, 32'h7FFF_FFFF, 0, 0, 0, 0, 0},
            '{1, 2, 32'h8000_0000, 1, 0, 0, 0, 0},
            '{0, 0, 32'hFFFF_8000, 0, 0, 0, 0, 0},
            '{1, 2, 32'h0000_0001, 1, 0, 0, 0, 0}
        };
        apb_write(REG_SIZE, 32'd2);
        foreach (dir_rows[i]) begin
            el = '{r: dir_rows[i].r, c: dir_rows[i].c, v: dir_rows[i].v, go: dir_rows[i].go};
            send_element(el, res);
            if (dir_rows[i].nexp == 0) begin
                foreach (res[j]) solution_q.insert(solution_q.size(), res[j]);
            end else begin
                for (int j = 0; j < dir_rows[i].nexp; j++) begin
                    e.idx = 3'(j);
                    e.val = (j == 0) ? dir_rows[i].x0 : dir_rows[i].x1;
                    e.sing = dir_rows[i].sing;
                    e.last = (j == dir_rows[i].nexp - 1);
                    solution_q.insert(solution_q.size(), e);
                end
            end
        end
        wait_drained();

        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct = idle_src[ph];
            snk_stall_pct = idle_snk[ph];
            for (int k = 0; k < 3; k++) begin
                apb_write(REG_SIZE, 32'(sizes[ph*3+k]));
                apb_write(REG_THR, 32'(thrs[ph*3+k]));
                // Hold the result channel while systems keep arriving, so the
                // request queue fills and the input stalls.
                if (ph == 0 && k == 0) hold_reqs++;
                cnt = 0;
                while (cnt < 20) begin
                    send_system(sent);
                    cnt += sent;
                end
                wait_drained();
            end
        end
        apb_write(REG_SIZE, 32'd8);
        apb_write(REG_THR, 32'd1);
        send_system(sent);
        wait_drained();

        if (fails == 0) begin
            $display("** givens_qr_linear_solver: PASSED **");
        end else begin
            $display("** givens_qr_linear_solver: FAILED **");
        end
        $finish;
    end

endmodule

// ===== givens_qr_linear_solver.f =====
hdl/gqr_pkg.sv
hdl/gqr_queue.sv
hdl/gqr_front.sv
hdl/gqr_div.sv
hdl/gqr_back.sv
hdl/givens_qr_linear_solver.sv
sim/tb_top.sv
